@@ rtl/core/rsm_pkg.sv @@
package rsm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 13;
  localparam int CORNER_W   = 14;
  localparam int ARC_W      = 40;
  localparam int DEPTH_W    = 11;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd1311;
  localparam logic [ARC_W-1:0]   ARC_MAX   = {ARC_W{1'b1}};

  localparam logic KIND_VERT = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  localparam logic [1:0] TEX_LEFT   = 2'd0;
  localparam logic [1:0] TEX_CENTRE = 2'd1;
  localparam logic [1:0] TEX_RIGHT  = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        road_width;
  } in_t;

  typedef struct packed {
    logic                item_kind;
    logic signed [31:0]  vert_x;
    logic signed [31:0]  vert_y;
    logic [1:0]          tex_u;
    logic [ARC_W-1:0]    tex_v;
    logic [ARC_W-1:0]    arc_length;
    logic [DEPTH_W-1:0]  depth_value;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic                run_end;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

endpackage

@@ rtl/core/rsm_mul.sv @@
module rsm_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  output logic [63:0]    prod,
  output rsm_pkg::stat_t stat
);
  import rsm_pkg::*;

  logic [63:0] p_r, p_nxt;
  logic [31:0] a_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] s;

  // add the multiplicand on a set low bit, then shift one bit right
  always_comb begin
    s     = {1'b0, p_r[63:32]} + (p_r[0] ? {1'b0, a_r} : 33'd0);
    p_nxt = {s, p_r[31:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {32'd0, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign prod = p_r;
  assign stat = '{busy: busy_r, done: done_r};
endmodule

@@ rtl/core/rsm_div.sv @@
module rsm_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    dividend,
  input  logic [39:0]    divisor,
  output logic [63:0]    quot,
  output rsm_pkg::stat_t stat
);
  import rsm_pkg::*;

  logic [63:0] q_r;
  logic [39:0] rem_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [40:0] rsh, rdif;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rsh  = {rem_r, q_r[63]};
    rdif = rsh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!rdif[40]) begin
        rem_r <= rdif[39:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= rsh[39:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign quot = q_r;
  assign stat = '{busy: busy_r, done: done_r};
endmodule

@@ rtl/core/road_strip_mesh_builder.sv @@
// Road strip mesh builder: turns the points of a closed track into road
// vertices and triangles.
// Input channel (in_valid/in_ready/in_data): one request per track point.
// Result channel (out_valid/out_ready/out_data): vertex and triangle records,
// run_end set on the last record a point causes. A point causes 0, 7, 10
// or 14 records.
// Configuration: cfg_we/cfg_wdata write point_count; write it only while idle.
// Each point's geometry runs through one shared shift-add multiplier, a
// bit-pair square root and one shared restoring divider. One vertex triple
// costs four products, one root and five quotients (three when the segment
// has zero length). The first record of a triple shows on out_valid once
// its products, root and quotients are done.
// in_ready is high only between points; a record waiting in the output
// register does not block the next request, but a stalled receiver holds
// the record emitter until its register frees.
// Reset (rst_n low, synchronous) clears the track state, sets point_count to
// two and empties the output register.
module road_strip_mesh_builder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsm_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [12:0]   cfg_wdata
);
  import rsm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MXX  = 13'b0000000000010,
    S_MYY  = 13'b0000000000100,
    S_SQRT = 13'b0000000001000,
    S_MOX  = 13'b0000000010000,
    S_DOX  = 13'b0000000100000,
    S_MOY  = 13'b0000001000000,
    S_DOY  = 13'b0000010000000,
    S_DDE  = 13'b0000100000000,
    S_DDC  = 13'b0001000000000,
    S_DTV  = 13'b0010000000000,
    S_EMIT = 13'b0100000000000,
    S_NEXT = 13'b1000000000000
  } state_t;

  state_t state_r;

  // track state
  logic [CNT_W-1:0]  pcount_r;
  logic signed [31:0] prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic [30:0]       prev_w_r;
  logic [IDX_W-1:0]  pidx_r;
  logic [ARC_W-1:0]  dsum_r;

  // current request
  logic signed [31:0] x_r, y_r;
  logic [30:0]       w_r;
  logic              lastp_r;

  // vertex triple under work
  logic signed [31:0] epx_r, epy_r, enx_r, eny_r;
  logic [30:0]       ew_r;
  logic [IDX_W-1:0]  eidx_r;
  logic [ARC_W-1:0]  earc_r;
  logic              phase_b_r;
  logic              go_r;

  logic [65:0] sq_r;
  logic [35:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic [31:0] ox_r, oy_r;
  logic [DEPTH_W-1:0] de_r, dc_r;
  logic [ARC_W-1:0]   tv_r;
  logic [2:0]  rec_r;

  logic  out_valid_r;
  out_t  out_data_r, rec_data;

  // effective count and its derived values
  logic [CNT_W-1:0] n_eff;
  logic [19:0]      den;
  logic             lastp;
  assign n_eff = (pcount_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pcount_r;
  assign den   = ({7'd0, n_eff} << 6) + ({7'd0, n_eff} << 5) + ({7'd0, n_eff} << 2);
  assign lastp = ({1'b0, pidx_r} + 13'd1) >= n_eff;

  // segment deltas
  logic signed [32:0] dx, dy;
  logic [31:0] ax, ay;
  assign dx = {enx_r[31], enx_r} - {epx_r[31], epx_r};
  assign dy = {eny_r[31], eny_r} - {epy_r[31], epy_r};
  assign ax = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay = dy[32] ? 32'(-dy) : dy[31:0];

  // shared units
  logic        mul_start, div_start;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod, div_quot, div_num;
  logic [39:0] div_den;
  stat_t       mul_stat, div_stat;

  rsm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_prod), .stat(mul_stat)
  );

  rsm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_den), .quot(div_quot), .stat(div_stat)
  );

  logic [13:0] idx_sum;
  assign idx_sum = {2'd0, eidx_r} + {1'b0, n_eff};

  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (state_r)
      S_MYY: begin mul_a = ay; mul_b = ay; end
      S_MOX: begin mul_a = ay; mul_b = {1'b0, ew_r}; end
      S_MOY: begin mul_a = ax; mul_b = {1'b0, ew_r}; end
      default: ;
    endcase
  end

  always_comb begin
    div_num = mul_prod;
    div_den = {7'd0, root_r};
    case (state_r)
      S_DDE: begin div_num = {36'd0, eidx_r, 16'd0}; div_den = {20'd0, den}; end
      S_DDC: begin div_num = {34'd0, idx_sum, 16'd0}; div_den = {20'd0, den}; end
      S_DTV: begin div_num = {24'd0, earc_r}; div_den = 40'd100; end
      default: ;
    endcase
  end

  logic len_zero;
  assign len_zero = (root_r == 33'd0);

  assign mul_start = go_r && ((state_r == S_MXX) || (state_r == S_MYY) ||
                              (state_r == S_MOX) || (state_r == S_MOY));
  assign div_start = go_r && (((state_r == S_DOX) && !len_zero) ||
                              ((state_r == S_DOY) && !len_zero) ||
                              (state_r == S_DDE) || (state_r == S_DDC) ||
                              (state_r == S_DTV));

  // square root step
  logic [35:0] rsh, trial, rdif;
  assign rsh   = {rem_r[33:0], sq_r[65:64]};
  assign trial = {1'b0, root_r, 2'b01};
  assign rdif  = rsh - trial;

  // saturated depth from a quotient
  logic [DEPTH_W-1:0] dq_sat;
  assign dq_sat = (div_quot > 64'(DEPTH_MAX)) ? DEPTH_MAX : div_quot[DEPTH_W-1:0];

  // arc update after a segment
  logic [40:0]      dsum_add;
  logic [ARC_W-1:0] dsum_upd;
  assign dsum_add = {1'b0, dsum_r} + {8'd0, root_r};
  assign dsum_upd = dsum_add[40] ? ARC_MAX : dsum_add[ARC_W-1:0];

  // vertex offsets with sign and saturation
  logic        neg_x, neg_y;
  logic signed [33:0] oxs, oys, lx, ly, rx, ry;
  logic signed [31:0] lxs, lys, rxs, rys;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  assign neg_x = !dy[32] && (dy != 33'sd0);
  assign neg_y = dx[32];
  assign oxs = neg_x ? -$signed({2'b00, ox_r}) : $signed({2'b00, ox_r});
  assign oys = neg_y ? -$signed({2'b00, oy_r}) : $signed({2'b00, oy_r});
  assign lx  = {{2{epx_r[31]}}, epx_r} + oxs;
  assign ly  = {{2{epy_r[31]}}, epy_r} + oys;
  assign rx  = {{2{epx_r[31]}}, epx_r} - oxs;
  assign ry  = {{2{epy_r[31]}}, epy_r} - oys;
  assign lxs = sat32(lx);
  assign lys = sat32(ly);
  assign rxs = sat32(rx);
  assign rys = sat32(ry);

  // record selection
  logic [CORNER_W-1:0] b0, b1, b2, b3, b4, b5;
  logic [2:0] rec_last;
  logic       is_last_rec, slot_free, emit_fire;
  assign b0 = {2'd0, eidx_r} + {1'b0, eidx_r, 1'b0};
  assign b1 = b0 + 14'd1;
  assign b2 = b0 + 14'd2;
  assign b3 = b0 + 14'd3;
  assign b4 = b0 + 14'd4;
  assign b5 = b0 + 14'd5;
  assign rec_last    = (phase_b_r && (eidx_r < IDX_W'(2))) ? 3'd2 : 3'd6;
  assign is_last_rec = (rec_r == rec_last);
  assign slot_free   = !out_valid_r || out_ready;
  assign emit_fire   = (state_r == S_EMIT) && slot_free;

  always_comb begin
    rec_data             = '0;
    rec_data.item_kind   = KIND_VERT;
    rec_data.tex_v       = tv_r;
    rec_data.arc_length  = earc_r;
    rec_data.run_end     = is_last_rec && (phase_b_r || !lastp_r);
    case (rec_r)
      3'd0: begin
        rec_data.vert_x = lxs; rec_data.vert_y = lys;
        rec_data.tex_u = TEX_LEFT; rec_data.depth_value = de_r;
      end
      3'd1: begin
        rec_data.vert_x = epx_r; rec_data.vert_y = epy_r;
        rec_data.tex_u = TEX_CENTRE; rec_data.depth_value = dc_r;
      end
      3'd2: begin
        rec_data.vert_x = rxs; rec_data.vert_y = rys;
        rec_data.tex_u = TEX_RIGHT; rec_data.depth_value = de_r;
      end
      default: begin
        rec_data.item_kind  = KIND_TRI;
        rec_data.tex_v      = '0;
        rec_data.arc_length = '0;
        case (rec_r)
          3'd3: begin
            rec_data.corner_a = b0;
            rec_data.corner_b = b1;
            rec_data.corner_c = phase_b_r ? 14'd0 : b3;
          end
          3'd4: begin
            rec_data.corner_a = phase_b_r ? 14'd0 : b3;
            rec_data.corner_b = b1;
            rec_data.corner_c = phase_b_r ? 14'd1 : b4;
          end
          3'd5: begin
            rec_data.corner_a = b1;
            rec_data.corner_b = b2;
            rec_data.corner_c = phase_b_r ? 14'd1 : b4;
          end
          default: begin
            rec_data.corner_a = phase_b_r ? 14'd1 : b4;
            rec_data.corner_b = b2;
            rec_data.corner_c = phase_b_r ? 14'd2 : b5;
          end
        endcase
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcount_r    <= CNT_W'(2);
      pidx_r      <= '0;
      dsum_r      <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_w_r    <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
      rec_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) pcount_r <= cfg_wdata;
      // drop the taken record unless the emitter refills the register
      if (out_ready && !emit_fire) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          // drop requests while the count is below two
          if (in_valid && (n_eff >= CNT_W'(2))) begin
            x_r     <= in_data.point_x;
            y_r     <= in_data.point_y;
            w_r     <= in_data.road_width;
            lastp_r <= lastp;
            if (pidx_r != '0) begin
              epx_r     <= prev_x_r;
              epy_r     <= prev_y_r;
              ew_r      <= prev_w_r;
              enx_r     <= in_data.point_x;
              eny_r     <= in_data.point_y;
              eidx_r    <= pidx_r - IDX_W'(1);
              earc_r    <= dsum_r;
              phase_b_r <= 1'b0;
              go_r      <= 1'b1;
              state_r   <= S_MXX;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_MXX: begin
          if (go_r) go_r <= 1'b0;
          else if (mul_stat.done) begin
            sq_r <= {2'd0, mul_prod};
            go_r <= 1'b1;
            state_r <= S_MYY;
          end
        end
        S_MYY: begin
          if (go_r) go_r <= 1'b0;
          else if (mul_stat.done) begin
            sq_r    <= sq_r + {2'd0, mul_prod};
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          // one root bit per cycle from the top bit pair
          sq_r  <= {sq_r[63:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
          if (!rdif[35]) begin
            rem_r  <= rdif;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= rsh;
            root_r <= {root_r[31:0], 1'b0};
          end
          if (cnt_r == 6'd32) begin
            go_r    <= 1'b1;
            state_r <= S_MOX;
          end
        end
        S_MOX: begin
          if (go_r) go_r <= 1'b0;
          else if (mul_stat.done) begin
            go_r <= 1'b1;
            state_r <= S_DOX;
          end
        end
        S_DOX: begin
          if (go_r && len_zero) begin
            ox_r    <= '0;
            state_r <= S_MOY;
          end else if (go_r) go_r <= 1'b0;
          else if (div_stat.done) begin
            ox_r    <= div_quot[31:0];
            go_r    <= 1'b1;
            state_r <= S_MOY;
          end
        end
        S_MOY: begin
          if (go_r) go_r <= 1'b0;
          else if (mul_stat.done) begin
            go_r <= 1'b1;
            state_r <= S_DOY;
          end
        end
        S_DOY: begin
          if (go_r && len_zero) begin
            oy_r    <= '0;
            state_r <= S_DDE;
          end else if (go_r) go_r <= 1'b0;
          else if (div_stat.done) begin
            oy_r    <= div_quot[31:0];
            go_r    <= 1'b1;
            state_r <= S_DDE;
          end
        end
        S_DDE: begin
          if (go_r) go_r <= 1'b0;
          else if (div_stat.done) begin
            de_r <= dq_sat;
            go_r <= 1'b1;
            state_r <= S_DDC;
          end
        end
        S_DDC: begin
          if (go_r) go_r <= 1'b0;
          else if (div_stat.done) begin
            dc_r <= dq_sat;
            go_r <= 1'b1;
            state_r <= S_DTV;
          end
        end
        S_DTV: begin
          if (go_r) go_r <= 1'b0;
          else if (div_stat.done) begin
            tv_r    <= div_quot[ARC_W-1:0];
            rec_r   <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold each record until the output register frees
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rec_data;
            rec_r       <= rec_r + 3'd1;
            if (is_last_rec) begin
              if (!phase_b_r) begin
                dsum_r <= dsum_upd;
                if (lastp_r) begin
                  // closing triple: current point faces the first point
                  epx_r     <= x_r;
                  epy_r     <= y_r;
                  ew_r      <= w_r;
                  enx_r     <= first_x_r;
                  eny_r     <= first_y_r;
                  eidx_r    <= pidx_r;
                  earc_r    <= dsum_upd;
                  phase_b_r <= 1'b1;
                  go_r      <= 1'b1;
                  state_r   <= S_MXX;
                end else begin
                  state_r <= S_NEXT;
                end
              end else begin
                state_r <= S_NEXT;
              end
            end
          end
        end
        S_NEXT: begin
          if (pidx_r == '0) begin
            first_x_r <= x_r;
            first_y_r <= y_r;
          end
          prev_x_r <= x_r;
          prev_y_r <= y_r;
          prev_w_r <= w_r;
          if (lastp_r) begin
            pidx_r <= '0;
            dsum_r <= '0;
          end else begin
            pidx_r <= pidx_r + IDX_W'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

@@ rtl/core/rsm_checker.sv @@
module rsm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rsm_pkg::out_t out_data
);
  import rsm_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("waiting request withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_vert_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == KIND_VERT) |->
      (out_data.corner_a == '0) && (out_data.corner_b == '0) &&
      (out_data.corner_c == '0))
    else $error("vertex record carries corners");

  a_tri_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == KIND_TRI) |->
      (out_data.vert_x == '0) && (out_data.vert_y == '0) &&
      (out_data.tex_u == '0) && (out_data.depth_value == '0) &&
      (out_data.arc_length == '0))
    else $error("triangle record carries vertex data");

  a_tex_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tex_u != 2'd3) && (out_data.depth_value <= DEPTH_MAX))
    else $error("texture or depth out of range");
endmodule

bind road_strip_mesh_builder rsm_checker u_rsm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ sim/road_strip_mesh_builder_checker.sv @@
`timescale 1ns / 100ps

module road_strip_mesh_builder_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rsm_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rsm_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [12:0]   cfg_wdata,
  output int            fail_count,
  output int            pending
);
  import rsm_pkg::*;

  out_t               mesh_q[$];
  logic [CNT_W-1:0]   track_len_cfg;
  longint             last_x, last_y, start_x, start_y;
  logic [30:0]        last_w;
  int unsigned        next_idx;
  logic [ARC_W-1:0]   arc_sum;

  function automatic logic [65:0] int_sqrt(logic [65:0] s);
    logic [67:0] rem, root, trial;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | s[2*k +: 2];
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[65:0];
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [1:0] u,
                             logic [ARC_W-1:0] arc, longint unsigned depth);
    out_t r;
    r = '0;
    r.item_kind = KIND_VERT;
    r.vert_x = x;
    r.vert_y = y;
    r.tex_u = u;
    r.tex_v = arc / 100;
    r.arc_length = arc;
    r.depth_value = (depth > DEPTH_MAX) ? DEPTH_MAX : depth[DEPTH_W-1:0];
    mesh_q.insert(mesh_q.size(), r);
  endtask

  task automatic push_tri(int unsigned a, int unsigned b, int unsigned c);
    out_t r;
    r = '0;
    r.item_kind = KIND_TRI;
    r.corner_a = a[CORNER_W-1:0];
    r.corner_b = b[CORNER_W-1:0];
    r.corner_c = c[CORNER_W-1:0];
    mesh_q.insert(mesh_q.size(), r);
  endtask

  // Three vertices of one point, offset across the segment to (nx, ny).
  task automatic push_triple(longint px, longint py, logic [30:0] w, longint nx, longint ny,
                             int unsigned idx, logic [ARC_W-1:0] arc, int unsigned n,
                             output logic [65:0] seg);
    longint dx, dy, ox, oy;
    logic [65:0] ax, ay;
    longint unsigned den, de, dc;
    dx = nx - px;
    dy = ny - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    seg = int_sqrt(ax * ax + ay * ay);
    ox = 0;
    oy = 0;
    den = 100 * n;
    de = (65536 * longint'(idx)) / den;
    dc = (65536 * longint'(idx + n)) / den;
    if (seg != 0) begin
      ox = longint'((ay * w) / seg);
      oy = longint'((ax * w) / seg);
      if (dy > 0) ox = -ox;
      if (dx < 0) oy = -oy;
    end
    push_vertex(clamp32(px + ox), clamp32(py + oy), TEX_LEFT, arc, de);
    push_vertex(clamp32(px), clamp32(py), TEX_CENTRE, arc, dc);
    push_vertex(clamp32(px - ox), clamp32(py - oy), TEX_RIGHT, arc, de);
  endtask

  task automatic predict_point(in_t d);
    int unsigned n, i, b, last;
    int before_sz;
    longint x, y;
    logic [65:0] seg;
    logic [66:0] sum;
    n = (track_len_cfg > MAX_POINTS) ? MAX_POINTS : track_len_cfg;
    if (n < 2) return;
    x = d.point_x;
    y = d.point_y;
    before_sz = mesh_q.size();
    if (next_idx == 0) begin
      start_x = x;
      start_y = y;
    end else begin
      i = next_idx - 1;
      b = 3 * i;
      push_triple(last_x, last_y, last_w, x, y, i, arc_sum, n, seg);
      push_tri(b, b + 1, b + 3);
      push_tri(b + 3, b + 1, b + 4);
      push_tri(b + 1, b + 2, b + 4);
      push_tri(b + 4, b + 2, b + 5);
      sum = arc_sum + seg;
      arc_sum = (sum > ARC_MAX) ? ARC_MAX : sum[ARC_W-1:0];
    end
    if (next_idx + 1 >= n) begin
      // close the track at this point
      last = 3 * next_idx;
      push_triple(x, y, d.road_width, start_x, start_y, next_idx, arc_sum, n, seg);
      if (next_idx >= 2) begin
        push_tri(last, last + 1, 0);
        push_tri(0, last + 1, 1);
        push_tri(last + 1, last + 2, 1);
        push_tri(1, last + 2, 2);
      end
      next_idx = 0;
      arc_sum = '0;
    end else begin
      next_idx++;
    end
    last_x = x;
    last_y = y;
    last_w = d.road_width;
    if (mesh_q.size() > before_sz) mesh_q[mesh_q.size()-1].run_end = 1'b1;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      track_len_cfg = 2;
      last_x = 0; last_y = 0; start_x = 0; start_y = 0;
      last_w = '0;
      next_idx = 0;
      arc_sum = '0;
      mesh_q.delete();
    end else begin
      if (cfg_we) track_len_cfg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (mesh_q.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = mesh_q.pop_front();
          check_field("item_kind", want.item_kind, out_data.item_kind);
          check_field("vert_x", want.vert_x, out_data.vert_x);
          check_field("vert_y", want.vert_y, out_data.vert_y);
          check_field("tex_u", want.tex_u, out_data.tex_u);
          check_field("tex_v", want.tex_v, out_data.tex_v);
          check_field("arc_length", want.arc_length, out_data.arc_length);
          check_field("depth_value", want.depth_value, out_data.depth_value);
          check_field("corner_a", want.corner_a, out_data.corner_a);
          check_field("corner_b", want.corner_b, out_data.corner_b);
          check_field("corner_c", want.corner_c, out_data.corner_c);
          check_field("run_end", want.run_end, out_data.run_end);
        end
      end
      if (in_valid && in_ready) predict_point(in_data);
    end
    pending = mesh_q.size();
  end

endmodule

@@ sim/road_strip_mesh_builder_tb.sv @@
`timescale 1ns / 100ps

module road_strip_mesh_builder_tb;
  import rsm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  int          fail_count;
  int          pending;

  // pacing knobs shared by the sender and the receiver
  bit          steady;
  bit          hold_req;
  int          points_sent;
  longint      px, py;

  road_strip_mesh_builder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  road_strip_mesh_builder_checker mesh_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random back-pressure, a quiet stretch, and one long hold-off
  // counted here in its own cycles.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 6000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Offer one request and hold it until taken; maybe idle afterwards.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [30:0] w);
    int gap;
    in_valid <= 1'b1;
    in_data <= {x, y, w};
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    points_sent++;
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all outstanding records, then let a first point finish too.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_track_len(logic [12:0] n);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random points: fully random, near the previous one, or repeated.
  task automatic random_point();
    int pick;
    logic [30:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      px = $signed($urandom());
      py = $signed($urandom());
    end else if (pick < 90) begin
      px = $signed(32'(px + $signed($urandom_range(0, 2000000) - 1000000)));
      py = $signed(32'(py + $signed($urandom_range(0, 2000000) - 1000000)));
    end
    w = ($urandom_range(0, 1)) ? 31'($urandom()) : 31'($urandom_range(0, 500000));
    send_point(px[31:0], py[31:0], w);
  endtask

  initial begin
    int reps;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_req = 1'b0;
    points_sent = 0;
    px = 0;
    py = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of two: extreme corners, no closing triangles.
    send_point(32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 31'h7fffffff);
    // Three points with a zero-length segment and the loop closed.
    set_track_len(13'd3);
    send_point(32'h80000000, 32'h7fffffff, 31'h0);
    send_point(32'h80000000, 32'h7fffffff, 31'h7fffffff);
    send_point(32'h7fffffff, 32'h80000000, 31'h12345);
    // Counts below two: requests are swallowed.
    set_track_len(13'd0);
    send_point(32'h00010000, 32'h00020000, 31'h10000);
    set_track_len(13'd1);
    send_point(32'h00030000, 32'h00040000, 31'h10000);
    // Largest count (clamped): bounce between corners for long segments.
    set_track_len(13'h1fff);
    for (int k = 0; k < 40; k++) begin
      if (k[0]) send_point(32'h7fffffff, 32'h7fffffff, 31'($urandom()));
      else send_point(32'h80000000, 32'h80000000, 31'($urandom()));
    end
    // Shrink the count mid-track: the next point closes it.
    set_track_len(13'd3);
    send_point(32'h00050000, 32'hfffb0000, 31'h8000);

    // Random tracks over several counts.
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0: set_track_len(13'd2);
        1: set_track_len(13'd3);
        2: set_track_len(13'd4);
        default: set_track_len(13'($urandom_range(5, 12)));
      endcase
      steady = (phase == 4);
      reps = 12;
      for (int k = 0; k < reps; k++) begin
        if (phase == 2 && k == 3) hold_req = 1'b1;
        random_point();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Sent %0d points over track lengths 0 to 4096, including corner-to-corner",
             points_sent);
    $display("segments, zero-length segments, a mid-track count change and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
